@@ design/f2i_pkg.sv @@
`default_nettype none
package f2i_pkg;
    localparam int unsigned SpFracBits = 23;
    localparam int unsigned DpFracBits = 52;
    localparam int unsigned SpBias = 127;
    localparam int unsigned DpBias = 1023;

    typedef struct packed {
        logic       neg;
        logic       is_nan;
        logic       is_inf;
        logic       below_one;
        logic [10:0] unb_exp;    // unbiased exponent when in normal range
        logic [52:0] sig;        // significand with hidden bit, LSB aligned
    } f2i_fields_t;
endpackage
`default_nettype wire

@@ design/f2i_core.sv @@
`default_nettype none
module f2i_core
    import f2i_pkg::*;
(
    input  wire logic [63:0]     arg_bits,
    input  wire logic            src_is_double,
    input  wire logic            dst_is_long,
    output logic      [63:0]     int_result
);
    f2i_fields_t f;
    logic [10:0] expf;
    logic [51:0] frac;
    logic [6:0]  sat_lim;
    logic [63:0] max_pos;
    logic [63:0] sat_val;
    logic [63:0] mag;
    logic [63:0] sig_ext;
    logic [5:0]  fb;

    always_comb begin
        if (src_is_double) begin
            f.neg = arg_bits[63];
            expf  = arg_bits[62:52];
            frac  = arg_bits[51:0];
            f.is_nan = (expf == 11'h7ff) && (frac != '0);
            f.is_inf = (expf == 11'h7ff) && (frac == '0);
            f.below_one = (expf < 11'(DpBias));
            f.unb_exp = expf - 11'(DpBias);
            f.sig = {1'b1, frac};
            fb = 6'(DpFracBits);
        end else begin
            f.neg = arg_bits[31];
            expf  = {3'b0, arg_bits[30:23]};
            frac  = {29'b0, arg_bits[22:0]};
            f.is_nan = (expf == 11'h0ff) && (frac != '0);
            f.is_inf = (expf == 11'h0ff) && (frac == '0);
            f.below_one = (expf < 11'(SpBias));
            f.unb_exp = expf - 11'(SpBias);
            f.sig = {29'b0, 1'b1, arg_bits[22:0]};
            fb = 6'(SpFracBits);
        end

        sat_lim = dst_is_long ? 7'd63 : 7'd31;
        max_pos = dst_is_long ? 64'h7fff_ffff_ffff_ffff : 64'h0000_0000_7fff_ffff;
        sat_val = f.neg ? (64'd0 - max_pos - 64'd1) : max_pos;
        sig_ext = {11'b0, f.sig};
        // exponent below width-1 here, so it fits in 6 bits
        if (f.unb_exp[5:0] >= fb) begin
            mag = sig_ext << (f.unb_exp[5:0] - fb);
        end else begin
            mag = sig_ext >> (fb - f.unb_exp[5:0]);
        end

        if (f.is_nan) begin
            int_result = '0;
        end else if (f.is_inf) begin
            int_result = sat_val;
        end else if (f.below_one) begin
            int_result = '0;     // zero, subnormal, magnitude below one
        end else if (f.unb_exp >= {4'b0, sat_lim}) begin
            int_result = sat_val;
        end else begin
            int_result = f.neg ? (64'd0 - mag) : mag;
        end
    end
endmodule
`default_nettype wire

@@ design/float_to_integer_saturating_top.sv @@
`default_nettype none
// Channel | Dir | tdata                                 | tuser
// s_      | in  | [63:0] arg_bits                       | [0] src_is_double, [1] dst_is_long
// m_      | out | [63:0] int_result (signed)            | none
// One beat per cycle sustained while m_tready stays high; an accepted beat passes through the
// input register and then the result register before m_ valid. The conversion is one
// combinational pass between them. Reset (aresetn low, synchronous) clears both valid flags only.
// A stall on m_ holds the result; the input stage keeps filling until both are full.
module float_to_integer_saturating_top
    import f2i_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] arg_bits
    input  wire logic [1:0]  s_tuser,   // [0] src_is_double, [1] dst_is_long
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata    // [63:0] int_result
);
    logic        in_valid_reg;
    logic [63:0] in_bits_reg;
    logic [1:0]  in_user_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] conv;
    logic        out_load;

    f2i_core u_core (
        .arg_bits      (in_bits_reg),
        .src_is_double (in_user_reg[0]),
        .dst_is_long   (in_user_reg[1]),
        .int_result    (conv)
    );

    // result register frees when empty or taken this cycle
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_bits_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (out_load) begin
            out_data_reg <= conv;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("accepted with both stages full");
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("loaded result lost");
endmodule
`default_nettype wire
